// File: hdl/bsp_pkg.sv
package bsp_pkg;

   // response frame size for a button scan
   localparam int PAYLOAD_BYTES = 8;

   localparam int BANK_WIDTH   = 8;
   localparam int SAMPLE_WIDTH = 5;

   localparam logic [1:0] OUTCOME_IDLE    = 2'd0;
   localparam logic [1:0] OUTCOME_SUCCESS = 2'd1;
   localparam logic [1:0] OUTCOME_FAILURE = 2'd2;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_BUTTONS = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   localparam logic [2:0] CMD_SCAN   = 3'd3;
   localparam logic [2:0] CMD_STATUS = 3'd5;

   localparam logic [7:0] TYPE_MASK      = 8'he0;
   localparam logic [7:0] TYPE_PRIMARY   = 8'he0;
   localparam logic [7:0] TYPE_SECONDARY = 8'hc0;
   localparam logic [7:0] SAMPLE_MASK    = 8'h1f;
   localparam int         READY_BIT      = 1;

   localparam logic [3:0] PHASE_NONE  = 4'd0;
   localparam logic [3:0] PHASE_ONE   = 4'd1;
   localparam logic [3:0] PHASE_TWO   = 4'd2;
   localparam logic [3:0] PHASE_FOUR  = 4'd4;
   localparam logic [3:0] PHASE_EIGHT = 4'd8;

   localparam logic [6:0] LENGTH_SCAN   = 7'(PAYLOAD_BYTES);
   localparam logic [6:0] LENGTH_STATUS = 7'd1;

   typedef struct packed {
      logic [1:0] outcome;
      logic [6:0] frame_length;
      logic [7:0] frame_second_byte;
      logic [7:0] frame_last_byte;
   } item_type;

   typedef struct packed {
      logic [BANK_WIDTH-1:0] low;
      logic [BANK_WIDTH-1:0] mid;
      logic [BANK_WIDTH-1:0] high;
   } bank_set_type;

   typedef struct packed {
      logic [3:0]   phase;
      bank_set_type banks;
      logic [1:0]   pending_kind;
      logic         status_asked;
   } state_type;

   typedef struct packed {
      logic [2:0]   request_command;
      logic [3:0]   request_phase;
      logic [6:0]   request_length;
      bank_set_type banks;
   } result_type;

endpackage

// File: hdl/button_scan_poller.sv
// a taken word passes through the input register and then the result register before it shows up on the rsp_ side
// throughput: one word per cycle while rsp_stall is low; the input register refills while the result register drains
// state (phase, banks, pending kind, status flag) advances as a word moves into the result register
// synchronous active-high reset empties both registers and clears phase, banks and pending kind
// the first result after reset is always the status request
module button_scan_poller
   import bsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_outcome,
   input  logic [6:0] req_frame_length,
   input  logic [7:0] req_frame_second_byte,
   input  logic [7:0] req_frame_last_byte,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_request_command,
   output logic [3:0] rsp_request_phase,
   output logic [6:0] rsp_request_length,
   output logic [7:0] rsp_bank_low,
   output logic [7:0] rsp_bank_mid,
   output logic [7:0] rsp_bank_high
);

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   item_ff;
   item_type   item_in;

   // controller state
   state_type  state_ff;
   state_type  state_in;
   state_type  state_next;

   // result register
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type result_ff;
   result_type result_in;
   result_type result_next;

   logic       advance;
   logic       req_take;

   // a word leaves the input register when the result register is empty or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   bsp_step u_step (
      .item       (item_ff),
      .state      (state_ff),
      .state_next (state_next),
      .result     (result_next)
   );

   // input side
   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_take) begin
         in_valid_in               = 1'b1;
         item_in.outcome           = req_outcome;
         item_in.frame_length      = req_frame_length;
         item_in.frame_second_byte = req_frame_second_byte;
         item_in.frame_last_byte   = req_frame_last_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // state and result side
   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      result_in    = result_ff;
      if (advance) begin
         state_in     = state_next;
         out_valid_in = 1'b1;
         result_in    = result_next;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_request_command = result_ff.request_command;
   assign rsp_request_phase   = result_ff.request_phase;
   assign rsp_request_length  = result_ff.request_length;
   assign rsp_bank_low        = result_ff.banks.low;
   assign rsp_bank_mid        = result_ff.banks.mid;
   assign rsp_bank_high       = result_ff.banks.high;

   // a scan request always carries a one-hot phase
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.request_command == CMD_SCAN) |-> $onehot(result_ff.request_phase))
      else $error("scan request without one-hot phase");

   // a status request carries no phase and a single byte
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.request_command == CMD_STATUS) |->
         (result_ff.request_phase == PHASE_NONE && result_ff.request_length == LENGTH_STATUS))
      else $error("malformed status request");

   // a pending button scan implies a live one-hot phase
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.pending_kind == KIND_BUTTONS) |-> $onehot(state_ff.phase))
      else $error("button scan pending with bad phase");

   // something pending means status has been asked already
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.pending_kind != KIND_NONE) |-> state_ff.status_asked)
      else $error("request pending before status was asked");

   // state only moves when a word passes into the result register
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a word moving");

endmodule

// File: hdl/bsp_scatter.sv
module bsp_scatter
   import bsp_pkg::*;
(
   input  logic [3:0]              phase,
   input  logic                    secondary,
   input  logic [SAMPLE_WIDTH-1:0] sample,
   input  bank_set_type            banks_in,
   output bank_set_type            banks_out
);

   // fixed per-phase bit maps from sample bits into the banks
   always_comb begin
      banks_out = banks_in;
      case (phase)
         PHASE_ONE: begin
            banks_out.high[5] = sample[0];
            banks_out.high[1] = sample[3];
            banks_out.mid[2]  = sample[4];
            banks_out.mid[1]  = sample[2];
            if (secondary) begin
               banks_out.high[3] = sample[1];
            end
         end
         PHASE_TWO: begin
            banks_out.mid[3] = sample[0];
            banks_out.mid[5] = sample[3];
            banks_out.mid[4] = sample[4];
            banks_out.mid[7] = sample[1];
            banks_out.mid[6] = sample[2];
         end
         PHASE_FOUR: begin
            banks_out.low[4] = sample[2];
            banks_out.low[6] = sample[1];
            banks_out.low[5] = sample[4];
            banks_out.low[7] = sample[3];
            banks_out.mid[0] = sample[0];
         end
         PHASE_EIGHT: begin
            banks_out.low[3]  = sample[3];
            banks_out.low[1]  = sample[4];
            banks_out.low[2]  = sample[1];
            banks_out.low[0]  = sample[2];
            banks_out.high[2] = sample[0];
         end
         default: begin
         end
      endcase
   end

endmodule

// File: hdl/bsp_step.sv
module bsp_step
   import bsp_pkg::*;
(
   input  item_type   item,
   input  state_type  state,
   output state_type  state_next,
   output result_type result
);

   logic [7:0]              type_bits;
   logic [7:0]              sample_bits;
   logic                    type_ok;
   logic                    frame_ok;
   logic                    buttons_pending;
   logic                    take;
   logic                    wipe;
   logic [3:0]              phase_shifted;
   bank_set_type            scattered;
   bank_set_type            banks_next;

   assign type_bits   = item.frame_second_byte & TYPE_MASK;
   assign sample_bits = item.frame_second_byte & SAMPLE_MASK;
   assign type_ok     = (type_bits == TYPE_PRIMARY) || (type_bits == TYPE_SECONDARY);
   assign frame_ok    = (item.frame_length == LENGTH_SCAN) &&
                        item.frame_last_byte[READY_BIT] && type_ok;

   assign buttons_pending = (state.pending_kind == KIND_BUTTONS);
   assign take = buttons_pending && (item.outcome == OUTCOME_SUCCESS) && frame_ok;
   assign wipe = buttons_pending && (item.outcome == OUTCOME_FAILURE);

   bsp_scatter u_scatter (
      .phase     (state.phase),
      .secondary (type_bits == TYPE_SECONDARY),
      .sample    (sample_bits[SAMPLE_WIDTH-1:0]),
      .banks_in  (state.banks),
      .banks_out (scattered)
   );

   always_comb begin
      if (take) begin
         banks_next = scattered;
      end else if (wipe) begin
         banks_next = '0;
      end else begin
         banks_next = state.banks;
      end
   end

   assign phase_shifted = state.phase >> 1;

   always_comb begin
      state_next       = state;
      state_next.banks = banks_next;
      result.banks     = banks_next;
      if (state.status_asked) begin
         // rotate 8, 4, 2, 1 and wrap back to 8
         state_next.phase        = (phase_shifted == PHASE_NONE) ? PHASE_EIGHT : phase_shifted;
         state_next.pending_kind = KIND_BUTTONS;
         result.request_command  = CMD_SCAN;
         result.request_phase    = state_next.phase;
         result.request_length   = LENGTH_SCAN;
      end else begin
         state_next.pending_kind = KIND_STATUS;
         state_next.status_asked = 1'b1;
         result.request_command  = CMD_STATUS;
         result.request_phase    = PHASE_NONE;
         result.request_length   = LENGTH_STATUS;
      end
   end

endmodule

// File: dv/tb_button_scan_poller.sv
`timescale 1ns / 1ps

module tb_button_scan_poller
   import bsp_pkg::*;
();

   // outcome code the block treats like idle
   localparam logic [1:0] OUTCOME_RESERVED = 2'd3;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_WORDS  = 400;
   localparam int IDLE_PERCENT  = 17;
   localparam int SETTLE_CYCLES = 4;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #HALF_PERIOD clock = ~clock;

   // request side, known from time zero
   logic       req_valid             = 1'b0;
   logic       req_stall;
   logic [1:0] req_outcome           = OUTCOME_IDLE;
   logic [6:0] req_frame_length      = '0;
   logic [7:0] req_frame_second_byte = '0;
   logic [7:0] req_frame_last_byte   = '0;

   // result side
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_request_command;
   logic [3:0] rsp_request_phase;
   logic [6:0] rsp_request_length;
   logic [7:0] rsp_bank_low;
   logic [7:0] rsp_bank_mid;
   logic [7:0] rsp_bank_high;

   button_scan_poller DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_outcome           (req_outcome),
      .req_frame_length      (req_frame_length),
      .req_frame_second_byte (req_frame_second_byte),
      .req_frame_last_byte   (req_frame_last_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_request_command   (rsp_request_command),
      .rsp_request_phase     (rsp_request_phase),
      .rsp_request_length    (rsp_request_length),
      .rsp_bank_low          (rsp_bank_low),
      .rsp_bank_mid          (rsp_bank_mid),
      .rsp_bank_high         (rsp_bank_high)
   );

   // shadow copy of the poller state
   logic [3:0] poll_phase   = PHASE_NONE;
   logic [7:0] bank_bits[3] = '{8'h00, 8'h00, 8'h00};
   logic [1:0] pending      = KIND_NONE;
   bit         status_sent  = 1'b0;

   // requests and banks still owed by the block, oldest first
   result_type pending_requests[$];

   int  error_count   = 0;
   int  words_sent    = 0;
   int  results_seen  = 0;
   int  scans_applied = 0;
   int  banks_cleared = 0;
   bit  quiet         = 1'b0;  // no idling on either side while set

   // directed stimulus: one exchange per row, typed answer where obvious
   typedef struct {
      item_type   word;
      bit         typed;
      result_type answer;
   } row_type;

   row_type directed_rows[$];

   function automatic void add_row(input logic [1:0] outcome, input logic [6:0] length,
                                   input logic [7:0] second, input logic [7:0] last,
                                   input bit typed, input logic [2:0] cmd,
                                   input logic [3:0] phase, input logic [6:0] req_len);
      row_type r;
      r.word           = '{outcome, length, second, last};
      r.typed          = typed;
      r.answer         = '0;
      r.answer.request_command = cmd;
      r.answer.request_phase   = phase;
      r.answer.request_length  = req_len;
      directed_rows.push_back(r);
   endfunction

   // next request and banks after one finished exchange
   function automatic result_type next_request(input item_type w);
      result_type r;
      logic [4:0] s;
      logic [7:0] kind;
      s    = w.frame_second_byte[4:0];
      kind = w.frame_second_byte & TYPE_MASK;
      // only an answer to a scan request touches the banks
      if (pending == KIND_BUTTONS) begin
         if (w.outcome == OUTCOME_FAILURE) begin
            bank_bits[0] = '0;
            bank_bits[1] = '0;
            bank_bits[2] = '0;
            banks_cleared++;
         end else if (w.outcome == OUTCOME_SUCCESS && w.frame_length == LENGTH_SCAN &&
                      w.frame_last_byte[READY_BIT] &&
                      (kind == TYPE_PRIMARY || kind == TYPE_SECONDARY)) begin
            scans_applied++;
            // scatter by the map of the phase that was asked for
            case (poll_phase)
               PHASE_ONE: begin
                  bank_bits[2][5] = s[0];
                  bank_bits[2][1] = s[3];
                  bank_bits[1][2] = s[4];
                  bank_bits[1][1] = s[2];
                  // extra bit only for the secondary frame type
                  if (kind == TYPE_SECONDARY) bank_bits[2][3] = s[1];
               end
               PHASE_TWO: begin
                  bank_bits[1][3] = s[0];
                  bank_bits[1][5] = s[3];
                  bank_bits[1][4] = s[4];
                  bank_bits[1][7] = s[1];
                  bank_bits[1][6] = s[2];
               end
               PHASE_FOUR: begin
                  bank_bits[0][4] = s[2];
                  bank_bits[0][6] = s[1];
                  bank_bits[0][5] = s[4];
                  bank_bits[0][7] = s[3];
                  bank_bits[1][0] = s[0];
               end
               PHASE_EIGHT: begin
                  bank_bits[0][3] = s[3];
                  bank_bits[0][1] = s[4];
                  bank_bits[0][2] = s[1];
                  bank_bits[0][0] = s[2];
                  bank_bits[2][2] = s[0];
               end
               default: ;
            endcase
         end
      end
      // one status request first, then scans rotating 8, 4, 2, 1
      if (status_sent) begin
         poll_phase = poll_phase >> 1;
         if (poll_phase == PHASE_NONE) poll_phase = PHASE_EIGHT;
         pending = KIND_BUTTONS;
         r.request_command = CMD_SCAN;
         r.request_phase   = poll_phase;
         r.request_length  = LENGTH_SCAN;
      end else begin
         pending     = KIND_STATUS;
         status_sent = 1'b1;
         r.request_command = CMD_STATUS;
         r.request_phase   = PHASE_NONE;
         r.request_length  = LENGTH_STATUS;
      end
      r.banks.low  = bank_bits[0];
      r.banks.mid  = bank_bits[1];
      r.banks.high = bank_bits[2];
      return r;
   endfunction

   // present one word and hold it until the block takes it
   task automatic send_word(input item_type w, input bit typed, input result_type answer);
      bit stalled;
      result_type predicted;
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_outcome           <= w.outcome;
      req_frame_length      <= w.frame_length;
      req_frame_second_byte <= w.frame_second_byte;
      req_frame_last_byte   <= w.frame_last_byte;
      // stall is stable mid-cycle, so sample it there for the coming edge
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      words_sent++;
      predicted = next_request(w);
      pending_requests.push_back(typed ? answer : predicted);
   endtask

   // hold off the sender until every owed result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_requests.size() != 0);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // result side: random stall, compare each taken word with the oldest owed one
   always begin : result_monitor
      bit         taken;
      result_type got;
      result_type want;
      @(negedge clock);
      taken = !reset && rsp_valid === 1'b1 && !rsp_stall;
      got.request_command = rsp_request_command;
      got.request_phase   = rsp_request_phase;
      got.request_length  = rsp_request_length;
      got.banks.low       = rsp_bank_low;
      got.banks.mid       = rsp_bank_mid;
      got.banks.high      = rsp_bank_high;
      @(posedge clock);
      if (taken) begin
         results_seen++;
         if (pending_requests.size() == 0) begin
            $error("result word with nothing owed");
            error_count++;
         end else begin
            want = pending_requests.pop_front();
            check_field("request_command", 8'(want.request_command),
                        8'(got.request_command));
            check_field("request_phase", 8'(want.request_phase), 8'(got.request_phase));
            check_field("request_length", 8'(want.request_length), 8'(got.request_length));
            check_field("bank_low", want.banks.low, got.banks.low);
            check_field("bank_mid", want.banks.mid, got.banks.mid);
            check_field("bank_high", want.banks.high, got.banks.high);
         end
      end
      rsp_stall <= !quiet && $urandom_range(99) < IDLE_PERCENT;
   end

   // stimulus
   initial begin : stimulus
      item_type   w;
      result_type none;
      int         pick;
      none = '0;

      // answers after reset: success with nothing pending, failure of the status ask
      add_row(OUTCOME_SUCCESS, LENGTH_SCAN, 8'hff, 8'h02, 1'b1, CMD_STATUS, PHASE_NONE,
              LENGTH_STATUS);
      add_row(OUTCOME_FAILURE, LENGTH_SCAN, 8'hff, 8'h02, 1'b1, CMD_SCAN, PHASE_EIGHT,
              LENGTH_SCAN);
      // full samples through every phase map, both frame types
      add_row(OUTCOME_SUCCESS, LENGTH_SCAN, 8'hff, 8'h02, 1'b0, '0, '0, '0);
      add_row(OUTCOME_SUCCESS, LENGTH_SCAN, 8'hdf, 8'hff, 1'b0, '0, '0, '0);
      add_row(OUTCOME_SUCCESS, LENGTH_SCAN, 8'hff, 8'h02, 1'b0, '0, '0, '0);
      add_row(OUTCOME_SUCCESS, LENGTH_SCAN, 8'hdf, 8'h02, 1'b0, '0, '0, '0);
      add_row(OUTCOME_SUCCESS, LENGTH_SCAN, 8'he0, 8'h02, 1'b0, '0, '0, '0);
      // failed scan empties all banks
      add_row(OUTCOME_FAILURE, LENGTH_SCAN, 8'hff, 8'h02, 1'b1, CMD_SCAN, PHASE_TWO,
              LENGTH_SCAN);
      add_row(OUTCOME_SUCCESS, LENGTH_SCAN, 8'hff, 8'h02, 1'b0, '0, '0, '0);
      // phase one with the primary type leaves the extra bit alone
      add_row(OUTCOME_SUCCESS, LENGTH_SCAN, 8'hff, 8'h02, 1'b0, '0, '0, '0);
      // rejected frames: bad length, ready clear, wrong type
      add_row(OUTCOME_SUCCESS, 7'd7, 8'hff, 8'h02, 1'b0, '0, '0, '0);
      add_row(OUTCOME_SUCCESS, 7'd64, 8'hff, 8'h02, 1'b0, '0, '0, '0);
      add_row(OUTCOME_SUCCESS, 7'd0, 8'hff, 8'h02, 1'b0, '0, '0, '0);
      add_row(OUTCOME_SUCCESS, LENGTH_SCAN, 8'hff, 8'hfd, 1'b0, '0, '0, '0);
      add_row(OUTCOME_SUCCESS, LENGTH_SCAN, 8'hbf, 8'h02, 1'b0, '0, '0, '0);
      add_row(OUTCOME_SUCCESS, LENGTH_SCAN, 8'h1f, 8'h02, 1'b0, '0, '0, '0);
      // reserved outcome and idle apply nothing but still rotate
      add_row(OUTCOME_RESERVED, LENGTH_SCAN, 8'hff, 8'h02, 1'b0, '0, '0, '0);
      add_row(OUTCOME_IDLE, LENGTH_SCAN, 8'hff, 8'hff, 1'b0, '0, '0, '0);
      add_row(OUTCOME_SUCCESS, LENGTH_SCAN, 8'hc0, 8'hff, 1'b0, '0, '0, '0);
      add_row(OUTCOME_SUCCESS, 7'd127, 8'h00, 8'h00, 1'b0, '0, '0, '0);
      add_row(OUTCOME_FAILURE, 7'd0, 8'h00, 8'h00, 1'b1, CMD_SCAN, PHASE_ONE, LENGTH_SCAN);
      add_row(OUTCOME_SUCCESS, LENGTH_SCAN, 8'hd5, 8'h02, 1'b0, '0, '0, '0);
      add_row(OUTCOME_SUCCESS, LENGTH_SCAN, 8'hea, 8'h02, 1'b0, '0, '0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].answer);
      drain_results();

      // random part: mostly good scan answers with random samples, some noise
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         quiet = (n >= 150 && n < 250);
         if (n == 300) drain_results();
         pick = $urandom_range(99);
         if (pick < 70)      w.outcome = OUTCOME_SUCCESS;
         else if (pick < 82) w.outcome = OUTCOME_FAILURE;
         else if (pick < 94) w.outcome = OUTCOME_IDLE;
         else                w.outcome = OUTCOME_RESERVED;
         w.frame_length = ($urandom_range(99) < 85) ? LENGTH_SCAN : 7'($urandom_range(127));
         w.frame_second_byte = 8'($urandom_range(255));
         pick = $urandom_range(99);
         if (pick < 45)
            w.frame_second_byte = TYPE_PRIMARY | (w.frame_second_byte & SAMPLE_MASK);
         else if (pick < 88)
            w.frame_second_byte = TYPE_SECONDARY | (w.frame_second_byte & SAMPLE_MASK);
         w.frame_last_byte = 8'($urandom_range(255));
         if ($urandom_range(99) < 88) w.frame_last_byte[READY_BIT] = 1'b1;
         // pure noise word now and then
         if ($urandom_range(99) < 10) begin
            w.outcome      = 2'($urandom_range(3));
            w.frame_length = 7'($urandom_range(127));
         end
         send_word(w, 1'b0, none);
      end
      quiet = 1'b0;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d words, %0d results checked", words_sent, results_seen);
      $display("scan answers applied %0d, bank clears %0d", scans_applied, banks_cleared);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // safety net for a hung handshake
   initial begin : watchdog
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// File: button_scan_poller.f
hdl/bsp_pkg.sv
hdl/bsp_scatter.sv
hdl/bsp_step.sv
hdl/button_scan_poller.sv
dv/tb_button_scan_poller.sv
